// ===== sv/elpd_pkg.sv =====
// Package with the shared types, constants and decode values of the expansion link port.
`default_nettype none
package elpd_pkg;

  localparam int FIFO_DEPTH = 1024;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = FIFO_AW + 1;
  localparam logic [FIFO_CW-1:0] FIFO_DEPTH_C = FIFO_CW'(FIFO_DEPTH);

  localparam int BR_DEPTH = 122;
  localparam int BR_AW    = $clog2(BR_DEPTH);

  localparam logic [15:0] ADDR_VEC_LO = 16'hfffc;
  localparam logic [15:0] ADDR_VEC_HI = 16'hfffd;
  localparam logic [15:0] ADDR_RAM_LO = 16'h2184;
  localparam logic [15:0] ADDR_RAM_HI = 16'h21fd;
  localparam logic [15:0] ADDR_STATUS = 16'h21fe;
  localparam logic [15:0] ADDR_DATA   = 16'h21ff;

  localparam logic [7:0] BOOT_VEC_LO = 8'h84;
  localparam logic [7:0] BOOT_VEC_HI = 8'h21;
  localparam logic [7:0] BR_FILL     = 8'hdb;

  localparam int CFG_IW = 1;

  typedef enum logic [2:0] {
    KIND_CPU_READ  = 3'd0,
    KIND_CPU_WRITE = 3'd1,
    KIND_HOST_PUSH = 3'd2,
    KIND_HOST_POP  = 3'd3,
    KIND_BOOT_LOAD = 3'd4
  } kind_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_RESET_VECTOR   = 1'd0,
    CFG_LINK_CONNECTED = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_RAM   = 2'd1,
    SRC_TOCPU = 2'd2
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [7:0] rd_const;
    logic       host_valid;
    logic       push_dropped;
  } stage_t;

  function automatic logic [7:0] br_default(input logic [BR_AW-1:0] idx);
    logic [7:0] v;
    unique case (idx)
      BR_AW'(0): v = 8'h6c;
      BR_AW'(1): v = 8'hfc;
      BR_AW'(2): v = 8'hff;
      default:   v = BR_FILL;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/elpd_in_if.sv =====
// Interface of the input channel that carries bus and host items.
`default_nettype none
interface elpd_in_if import elpd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [23:0] address;
  logic [7:0]  data_in;

  modport source (output valid, kind, address, data_in, input ready);
  modport sink (input valid, kind, address, data_in, output ready);
endinterface
`default_nettype wire

// ===== sv/elpd_out_if.sv =====
// Interface of the result channel that carries one result per item.
`default_nettype none
interface elpd_out_if import elpd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] host_data;
  logic       host_valid;
  logic       push_dropped;

  modport source (output valid, read_data, host_data, host_valid, push_dropped, input ready);
  modport sink (input valid, read_data, host_data, host_valid, push_dropped, output ready);
endinterface
`default_nettype wire

// ===== sv/expansion_link_port_device_unit.sv =====
// Top level of the expansion link port: decode, boot RAM, both FIFOs and the result register.
// Stage B and then the result register hold each item; the FIFO and boot RAM memories
// each read one address per cycle. Throughput: one item per cycle unless out_ch.ready stalls.
// Reset (synchronous, active low) clears the booted flag, FIFO pointers and counts,
// the boot RAM valid bits and the configuration registers; the boot RAM then reads its default.
// No clearing pass is needed after reset.
`default_nettype none
module expansion_link_port_device_unit import elpd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  elpd_in_if.sink                in_ch,
  elpd_out_if.source             out_ch,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [15:0]       cfg_data
);

  logic [15:0] vec_r;
  logic        link_r;
  logic        booted_r, booted_nxt;

  logic [7:0]         br_mem [0:BR_DEPTH-1];
  logic [BR_DEPTH-1:0] br_valid_r;
  logic [7:0]         br_q_r;

  logic [7:0]         to_mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] to_head_r;
  logic [FIFO_CW-1:0] to_cnt_r;
  logic [7:0]         to_q_r;

  logic [7:0]         from_mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] from_head_r;
  logic [FIFO_CW-1:0] from_cnt_r;
  logic [7:0]         from_q_r;

  stage_t b_r, b_nxt;
  logic   b_valid_r;

  logic       out_valid_r;
  logic [7:0] out_rd_r, out_hd_r;
  logic       out_hv_r, out_drop_r;

  logic in_fire, adv_b;
  logic to_push, to_pop, from_push, from_pop, br_we, br_rd;
  logic a_low, a_vlo, a_vhi, a_ram, a_stat, a_data;
  logic [BR_AW-1:0] ram_idx, load_idx;
  logic [15:0] ram_off;
  logic to_full, from_full, to_empty, from_empty;
  logic [FIFO_AW-1:0] to_tail, from_tail;
  logic [7:0] status;

  function automatic logic [FIFO_AW-1:0] fifo_wrap(input logic [FIFO_AW:0] v);
    logic [FIFO_AW:0] w;
    w = (v >= (FIFO_AW+1)'(FIFO_DEPTH)) ? v - (FIFO_AW+1)'(FIFO_DEPTH) : v;
    return w[FIFO_AW-1:0];
  endfunction

  function automatic logic [FIFO_AW-1:0] fifo_inc(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_AW'(1);
  endfunction

  assign adv_b       = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !b_valid_r || adv_b;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign a_low   = !in_ch.address[22];
  assign a_vlo   = a_low && (in_ch.address[15:0] == ADDR_VEC_LO);
  assign a_vhi   = a_low && (in_ch.address[15:0] == ADDR_VEC_HI);
  assign a_ram   = a_low && (in_ch.address[15:0] >= ADDR_RAM_LO) &&
                   (in_ch.address[15:0] <= ADDR_RAM_HI);
  assign a_stat  = a_low && (in_ch.address[15:0] == ADDR_STATUS);
  assign a_data  = a_low && (in_ch.address[15:0] == ADDR_DATA);
  assign ram_off = in_ch.address[15:0] - ADDR_RAM_LO;
  assign ram_idx = ram_off[BR_AW-1:0];
  assign load_idx = in_ch.address[BR_AW-1:0];

  assign to_full    = (to_cnt_r == FIFO_DEPTH_C);
  assign from_full  = (from_cnt_r == FIFO_DEPTH_C);
  assign to_empty   = (to_cnt_r == '0);
  assign from_empty = (from_cnt_r == '0);
  assign to_tail    = fifo_wrap({1'b0, to_head_r} + to_cnt_r[FIFO_AW:0]);
  assign from_tail  = fifo_wrap({1'b0, from_head_r} + from_cnt_r[FIFO_AW:0]);
  assign status     = link_r ? {!to_empty, !from_full, 1'b1, 5'b0} : 8'h00;

  always_comb begin
    b_nxt      = '{src: SRC_CONST, rd_const: 8'h00, host_valid: 1'b0, push_dropped: 1'b0};
    booted_nxt = booted_r;
    to_push    = 1'b0;
    to_pop     = 1'b0;
    from_push  = 1'b0;
    from_pop   = 1'b0;
    br_we      = 1'b0;
    br_rd      = 1'b0;
    unique case (in_ch.kind)
      KIND_CPU_READ: begin
        b_nxt.rd_const = in_ch.data_in;
        priority if (a_vlo) begin
          b_nxt.rd_const = booted_r ? vec_r[7:0] : BOOT_VEC_LO;
        end else if (a_vhi) begin
          b_nxt.rd_const = booted_r ? vec_r[15:8] : BOOT_VEC_HI;
          booted_nxt     = 1'b1;
        end else if (a_ram) begin
          if (br_valid_r[ram_idx]) begin
            b_nxt.src = SRC_RAM;
            br_rd     = 1'b1;
          end else begin
            b_nxt.rd_const = br_default(ram_idx);
          end
        end else if (a_stat) begin
          b_nxt.rd_const = status;
        end else if (a_data && !to_empty) begin
          b_nxt.src = SRC_TOCPU;
          to_pop    = 1'b1;
        end else begin
          b_nxt.rd_const = in_ch.data_in;
        end
      end
      KIND_CPU_WRITE: begin
        if (a_data) begin
          b_nxt.push_dropped = from_full;
          from_push          = !from_full;
        end
      end
      KIND_HOST_PUSH: begin
        b_nxt.push_dropped = to_full;
        to_push            = !to_full;
      end
      KIND_HOST_POP: begin
        b_nxt.host_valid = !from_empty;
        from_pop         = !from_empty;
      end
      KIND_BOOT_LOAD: begin
        br_we = (in_ch.address < 24'(BR_DEPTH));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r  <= '0;
      link_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RESET_VECTOR:   vec_r  <= cfg_data;
        CFG_LINK_CONNECTED: link_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      booted_r    <= 1'b0;
      br_valid_r  <= '0;
      to_head_r   <= '0;
      to_cnt_r    <= '0;
      from_head_r <= '0;
      from_cnt_r  <= '0;
    end else if (in_fire) begin
      booted_r <= booted_nxt;
      if (br_we) begin
        br_valid_r[load_idx] <= 1'b1;
      end
      if (to_push) begin
        to_cnt_r <= to_cnt_r + FIFO_CW'(1);
      end else if (to_pop) begin
        to_cnt_r  <= to_cnt_r - FIFO_CW'(1);
        to_head_r <= fifo_inc(to_head_r);
      end
      if (from_push) begin
        from_cnt_r <= from_cnt_r + FIFO_CW'(1);
      end else if (from_pop) begin
        from_cnt_r  <= from_cnt_r - FIFO_CW'(1);
        from_head_r <= fifo_inc(from_head_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && br_we) begin
      br_mem[load_idx] <= in_ch.data_in;
    end
    if (in_fire && br_rd) begin
      br_q_r <= br_mem[ram_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && to_push) begin
      to_mem[to_tail] <= in_ch.data_in;
    end
    if (in_fire && to_pop) begin
      to_q_r <= to_mem[to_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && from_push) begin
      from_mem[from_tail] <= in_ch.data_in;
    end
    if (in_fire && from_pop) begin
      from_q_r <= from_mem[from_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      b_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_r <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_b) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && b_valid_r) begin
      unique case (b_r.src)
        SRC_RAM:   out_rd_r <= br_q_r;
        SRC_TOCPU: out_rd_r <= to_q_r;
        default:   out_rd_r <= b_r.rd_const;
      endcase
      out_hd_r   <= b_r.host_valid ? from_q_r : 8'h00;
      out_hv_r   <= b_r.host_valid;
      out_drop_r <= b_r.push_dropped;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_rd_r;
  assign out_ch.host_data    = out_hd_r;
  assign out_ch.host_valid   = out_hv_r;
  assign out_ch.push_dropped = out_drop_r;

`ifndef SYNTHESIS
  a_to_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    to_cnt_r <= FIFO_DEPTH_C) else $error("to_cpu count exceeds depth");

  a_from_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    from_cnt_r <= FIFO_DEPTH_C) else $error("from_cpu count exceeds depth");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (b_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

  a_booted_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    booted_r |=> booted_r) else $error("booted flag cleared without reset");
`endif

endmodule
`default_nettype wire
